// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fssm_pkg.sv =====
package fssm_pkg;

  localparam int MAX_NEEDLE   = 32;
  localparam int POS_BITS     = 32;
  localparam int OUT_W        = 32;
  localparam int LEN_W        = $clog2(MAX_NEEDLE + 1);
  localparam int IDX_W        = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int CFG_DATA_W   = 64;
  localparam int NEEDLE_WORDS = 4;
  localparam int CFG_ADDR_W   = 6;
  localparam int REG_SEL_W    = CFG_ADDR_W - 3;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_NEEDLE_0   = 3'd0,
    REG_NEEDLE_1   = 3'd1,
    REG_NEEDLE_2   = 3'd2,
    REG_NEEDLE_3   = 3'd3,
    REG_NEEDLE_LEN = 3'd4
  } reg_idx_t;

  typedef logic [7:0] text_t;

  typedef struct packed {
    logic [NEEDLE_WORDS*8-1:0][7:0] needle;
    logic [LEN_W-1:0]               len;
  } cfg_t;

endpackage

// ===== rtl/fssm_in_if.sv =====
interface fssm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

// ===== rtl/fssm_out_if.sv =====
interface fssm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_start;
  logic        overflow;

  modport source (output valid, found, match_start, overflow, input ready);
  modport sink (input valid, found, match_start, overflow, output ready);
endinterface

// ===== rtl/fssm_regs.sv =====
module fssm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fssm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fssm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fssm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output fssm_pkg::cfg_t                  cfg
);
  import fssm_pkg::*;

  logic [NEEDLE_WORDS-1:0][CFG_DATA_W-1:0] needle_words;
  logic [LEN_W-1:0]                        needle_len;
  reg_idx_t                                sel;
  logic                                    wr;

  assign sel    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_words <= '0;
      needle_len   <= LEN_W'(1);
    end else if (wr) begin
      case (sel)
        REG_NEEDLE_0:   needle_words[0] <= pwdata;
        REG_NEEDLE_1:   needle_words[1] <= pwdata;
        REG_NEEDLE_2:   needle_words[2] <= pwdata;
        REG_NEEDLE_3:   needle_words[3] <= pwdata;
        REG_NEEDLE_LEN: needle_len      <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_NEEDLE_0:   prdata = needle_words[0];
      REG_NEEDLE_1:   prdata = needle_words[1];
      REG_NEEDLE_2:   prdata = needle_words[2];
      REG_NEEDLE_3:   prdata = needle_words[3];
      REG_NEEDLE_LEN: prdata = CFG_DATA_W'(needle_len);
      default:        prdata = '0;
    endcase
  end

  // byte 0 sits lowest in word 0, so the flat word order is the byte order
  always_comb begin
    cfg.needle = needle_words;
    if (needle_len == '0) begin
      cfg.len = LEN_W'(1);
    end else if (needle_len > LEN_W'(MAX_NEEDLE)) begin
      cfg.len = LEN_W'(MAX_NEEDLE);
    end else begin
      cfg.len = needle_len;
    end
  end
endmodule

// ===== rtl/fssm_cell.sv =====
module fssm_cell (
  input  logic                clk,
  input  logic                shift,
  input  fssm_pkg::text_t     d_in,
  input  fssm_pkg::text_t     want_byte,
  input  logic                active,
  output fssm_pkg::text_t     d_out,
  output logic                hit
);
  import fssm_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      d_out <= d_in;
    end
  end

  // compare against the byte this cell will hold after the shift
  assign hit = !active || (d_in == want_byte);
endmodule

// ===== rtl/first_substring_match_search_core.sv =====
// channel     | dir | beat payload                         | handshake
// ------------+-----+--------------------------------------+------------
// text_in     | in  | text_byte, end_of_text               | valid/ready
// result_out  | out | found, match_start, overflow         | valid/ready
// apb         | in  | needle words 0-3, needle_len (64 bit) | psel/penable
//
// one text beat per cycle while text_in is ready; each beat shifts the cell row and checks one
// alignment in the same cycle against the needle
// the result is registered on the end_of_text beat and is valid in the next cycle
// text_in stalls only while a result waits and result_out is not ready
// rst (synchronous) clears counters and the result valid flag, needle_len = 1
module first_substring_match_search_core (
  input  logic                            clk,
  input  logic                            rst,
  fssm_in_if.sink                         text_in,
  fssm_out_if.source                      result_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fssm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fssm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fssm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fssm_pkg::*;

  cfg_t                cfg;
  text_t               win [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] hits;
  logic                take;
  logic                all_hit;

  logic [POS_BITS-1:0] cnt, cnt_next;
  logic [POS_BITS-1:0] first_start, first_next;
  logic [POS_BITS-1:0] len_ext;
  logic                sat, sat_next;
  logic                seen, seen_next;
  logic                match_now;

  logic                res_valid;
  logic                res_found;
  logic [OUT_W-1:0]    res_start;
  logic                res_ovf;

  fssm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign take = text_in.valid && text_in.ready;

  // cell j holds the byte j places back and checks needle[len-1-j]
  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
    logic [LEN_W-1:0] pos;
    logic             active;
    text_t            d_in;

    assign pos    = cfg.len - LEN_W'(j + 1);
    assign active = LEN_W'(j) < cfg.len;
    if (j == 0) begin : g_head
      assign d_in = text_in.text_byte;
    end else begin : g_link
      assign d_in = win[j-1];
    end

    fssm_cell u_cell (
      .clk       (clk),
      .shift     (take),
      .d_in      (d_in),
      .want_byte (cfg.needle[pos[IDX_W-1:0]]),
      .active    (active),
      .d_out     (win[j]),
      .hit       (hits[j])
    );
  end

  assign all_hit = &hits;
  assign len_ext = POS_BITS'(cfg.len);

  always_comb begin
    cnt_next = cnt;
    sat_next = sat;
    if (cnt == '1) begin
      sat_next = 1'b1;
    end else begin
      cnt_next = cnt + POS_BITS'(1);
    end
    // only alignments fully inside this search are checked
    match_now  = !seen && !sat_next && (cnt_next >= len_ext) && all_hit;
    seen_next  = seen || match_now;
    first_next = match_now ? (cnt_next - len_ext) : first_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      sat         <= 1'b0;
      seen        <= 1'b0;
      first_start <= '0;
      res_valid   <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (take && text_in.end_of_text) begin
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        if (text_in.end_of_text) begin
          cnt         <= '0;
          sat         <= 1'b0;
          seen        <= 1'b0;
          first_start <= '0;
        end else begin
          cnt         <= cnt_next;
          sat         <= sat_next;
          seen        <= seen_next;
          first_start <= first_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && text_in.end_of_text) begin
      res_found <= seen_next;
      res_start <= seen_next ? OUT_W'(first_next) : OUT_W'(cnt_next);
      res_ovf   <= sat_next;
    end
  end

  assign text_in.ready          = !res_valid || result_out.ready;
  assign result_out.valid       = res_valid;
  assign result_out.found       = res_found;
  assign result_out.match_start = res_start;
  assign result_out.overflow    = res_ovf;
endmodule

// ===== rtl/fssm_checker.sv =====
`include "assert_macros.svh"

module fssm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eot,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_start,
  input logic        out_ovf
);

  // a stalled result keeps its fields
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_start) && $stable(out_ovf)), "result changed while stalled")

  // the last text beat always yields a result on the next cycle
  `ASSERT_CLK(a_eot_result, clk, rst, (in_valid && in_ready && in_eot) |=> out_valid, "no result after end_of_text")

  // a fresh result needs an end_of_text beat just before it
  `ASSERT_CLK(a_no_spurious, clk, rst, (out_valid && !($past(out_valid) && !$past(out_ready))) |-> $past(in_valid && in_ready && in_eot), "result without end_of_text")

  // a waiting result that is not taken blocks the input side
  `ASSERT_ALWAYS(a_stall_in, clk, (!rst && out_valid && !out_ready) |-> !in_ready, "input taken over a stalled result")

endmodule

bind first_substring_match_search_core fssm_checker u_fssm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .in_eot    (text_in.end_of_text),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_found (result_out.found),
  .out_start (result_out.match_start),
  .out_ovf   (result_out.overflow)
);

// ===== tb/match_search_checker.sv =====
`timescale 1ns / 100ps

module match_search_checker
  import fssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  fssm_in_if                    text_ch,
  fssm_out_if                   result_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic        overflow;
  } search_result_t;

  logic [63:0]    needle_word [NEEDLE_WORDS];
  logic [5:0]     needle_len;
  text_t          recent [32];
  logic [31:0]    byte_count;
  bit             match_seen;
  logic [31:0]    first_start;
  bit             count_full;
  search_result_t expected_results [$];

  function automatic int unsigned span(logic [5:0] n);
    if (n == 0) return 1;
    if (n > MAX_NEEDLE) return MAX_NEEDLE;
    return n;
  endfunction

  task automatic clear_search();
    foreach (recent[i]) recent[i] = 8'h00;
    byte_count = '0;
    match_seen = 1'b0;
    first_start = '0;
    count_full = 1'b0;
  endtask

  always @(posedge clk) begin
    int unsigned    n;
    bit             hit;
    search_result_t got;
    search_result_t want;
    if (rst) begin
      foreach (needle_word[i]) needle_word[i] = '0;
      needle_len = 6'd1;
      clear_search();
      expected_results.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:3]))
          REG_NEEDLE_0:   needle_word[0] = pwdata;
          REG_NEEDLE_1:   needle_word[1] = pwdata;
          REG_NEEDLE_2:   needle_word[2] = pwdata;
          REG_NEEDLE_3:   needle_word[3] = pwdata;
          REG_NEEDLE_LEN: needle_len = pwdata[5:0];
          default: ;
        endcase
      end

      // results go first so a beat with nothing waiting is caught
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.found, result_ch.match_start, result_ch.overflow};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: found=%0d start=%0d overflow=%0d",
                     got.found, got.start, got.overflow);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.start !== want.start ||
              got.overflow !== want.overflow) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected found=%0d start=%0d overflow=%0d, %s",
                       want.found, want.start, want.overflow,
                       $sformatf("got found=%0d start=%0d overflow=%0d",
                                 got.found, got.start, got.overflow));
          end
        end
      end

      if (text_ch.valid && text_ch.ready) begin
        for (int i = 31; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = text_ch.text_byte;
        if (byte_count == '1) count_full = 1'b1;
        else byte_count++;
        n = span(needle_len);
        // only the alignment ending at this byte is new
        if (!match_seen && !count_full && byte_count >= n) begin
          hit = 1'b1;
          for (int i = 0; i < n; i++)
            if (needle_word[i/8][(i%8)*8 +: 8] != recent[n-1-i]) hit = 1'b0;
          if (hit) begin
            match_seen = 1'b1;
            first_start = byte_count - n;
          end
        end
        if (text_ch.end_of_text) begin
          want.found = match_seen;
          want.start = match_seen ? first_start : byte_count;
          want.overflow = count_full;
          expected_results.push_back(want);
          clear_search();
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/first_substring_match_search_core_test.sv =====
`timescale 1ns / 100ps

module first_substring_match_search_core_test;
  import fssm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;

  fssm_in_if  text_ch ();
  fssm_out_if result_ch ();

  first_substring_match_search_core dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_ch),
    .result_out (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  match_search_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .text_ch   (text_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  text_t       pattern [32];
  logic [5:0]  pattern_len;
  int unsigned beats_sent;
  bit          want_hold;

  // result side: random stalls, one quiet stretch, one long hold-off on request
  int unsigned rx_cycles;
  int unsigned hold_left;
  bit          hold_used;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (want_hold && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (rx_cycles >= 1500 && rx_cycles < 2500) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  function automatic int unsigned live_len();
    if (pattern_len == 0) return 1;
    if (pattern_len > MAX_NEEDLE) return MAX_NEEDLE;
    return pattern_len;
  endfunction

  function automatic logic [63:0] pattern_word(int w);
    logic [63:0] word;
    for (int j = 0; j < 8; j++) word[8*j +: 8] = pattern[8*w + j];
    return word;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_needle();
    write_reg(REG_NEEDLE_0, pattern_word(0));
    write_reg(REG_NEEDLE_1, pattern_word(1));
    write_reg(REG_NEEDLE_2, pattern_word(2));
    write_reg(REG_NEEDLE_3, pattern_word(3));
    write_reg(REG_NEEDLE_LEN, 64'(pattern_len));
  endtask

  task automatic send_beat(input text_t b, input logic last);
    if (!(beats_sent >= 600 && beats_sent < 900) && $urandom_range(0, 99) < 10) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.end_of_text <= last;
    do @(posedge clk); while (!text_ch.ready);
    beats_sent++;
  endtask

  // drain every result, then give the output register time to empty
  task automatic settle();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    text_t       hay [0:127];
    int unsigned act;
    int unsigned hay_len;
    int unsigned at;
    int unsigned phase_beats;
    bit          narrow;

    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.end_of_text = 1'b0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    want_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset needle is one zero byte
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    settle();

    // zero length acts as one
    foreach (pattern[i]) pattern[i] = text_t'($urandom);
    pattern[0] = 8'hFF;
    pattern_len = 6'd0;
    program_needle();
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    settle();

    // top of the length field clamps to 32, haystack shorter than needle
    pattern_len = 6'd63;
    program_needle();
    send_beat(8'h11, 1'b1);
    settle();

    pattern[0] = 8'h61;
    pattern[1] = 8'h62;
    pattern[2] = 8'h63;
    pattern_len = 6'd3;
    program_needle();
    send_beat(8'h61, 1'b0);
    send_beat(8'h62, 1'b1);
    send_beat(8'h61, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(8'h63, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(8'h63, 1'b1);
    settle();

    // needle changes halfway through a haystack
    pattern[0] = 8'h78;
    pattern[1] = 8'h79;
    pattern_len = 6'd2;
    program_needle();
    send_beat(8'h71, 1'b0);
    send_beat(8'h78, 1'b0);
    settle();
    pattern[0] = 8'h7A;
    pattern_len = 6'd1;
    program_needle();
    send_beat(8'h7A, 1'b1);

    for (int ph = 0; ph < 13; ph++) begin
      settle();
      narrow = ($urandom_range(0, 1) != 0);
      foreach (pattern[i]) begin
        case ($urandom_range(0, 2))
          0: pattern[i] = 8'h00;
          1: pattern[i] = 8'hFF;
          default: pattern[i] = 8'hA5;
        endcase
        if (!narrow) pattern[i] = text_t'($urandom);
      end
      case (ph)
        0: pattern_len = 6'd1;
        1: pattern_len = 6'd32;
        2: pattern_len = 6'd0;
        3: pattern_len = 6'd63;
        4: pattern_len = 6'd2;
        5: pattern_len = 6'd33;
        default: pattern_len = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(1, 8));
      endcase
      program_needle();
      act = live_len();
      if (ph == 7) want_hold <= 1'b1;
      phase_beats = 0;
      while (phase_beats < 115) begin
        hay_len = $urandom_range(1, act + 10);
        if ($urandom_range(0, 9) == 0) hay_len = $urandom_range(1, 3 * act + 20);
        for (int k = 0; k < hay_len; k++)
          hay[k] = ($urandom_range(0, 3) == 0) ? text_t'($urandom)
                                               : pattern[$urandom_range(0, act - 1)];
        if (hay_len >= act && $urandom_range(0, 9) < 6) begin
          at = $urandom_range(0, hay_len - act);
          for (int k = 0; k < act; k++) hay[at + k] = pattern[k];
          // near miss: one byte of the planted copy spoiled
          if ($urandom_range(0, 4) == 0)
            hay[at + $urandom_range(0, act - 1)] ^= text_t'($urandom_range(1, 255));
        end
        for (int k = 0; k < hay_len; k++) send_beat(hay[k], k == hay_len - 1);
        phase_beats += hay_len;
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== first_substring_match_search_core.f =====
+incdir+rtl
rtl/fssm_pkg.sv
rtl/fssm_in_if.sv
rtl/fssm_out_if.sv
rtl/fssm_regs.sv
rtl/fssm_cell.sv
rtl/first_substring_match_search_core.sv
rtl/fssm_checker.sv
tb/match_search_checker.sv
tb/first_substring_match_search_core_test.sv
